>>> src/gsfp_pkg.sv
// ----------------------------------------------------------------------------
// gsfp_pkg
// Shared constants for the gas sensor frame parser: frame bytes, field
// positions and configuration register map.
// ----------------------------------------------------------------------------
package gsfp_pkg;

    localparam int unsigned DataW  = 8;
    localparam int unsigned ValueW = 16;
    localparam int unsigned PosW   = 4;
    localparam int unsigned AddrW  = 3;
    localparam int unsigned ApbW   = 32;

    localparam logic [DataW-1:0] START_BYTE  = 8'hFF;
    localparam logic [DataW-1:0] PASSIVE_CMD = 8'h86;
    localparam logic [DataW-1:0] ACTIVE_GAS  = 8'h17;
    localparam logic [DataW-1:0] ACTIVE_UNIT = 8'h04;
    localparam logic [DataW-1:0] ACTIVE_DEC  = 8'h00;

    // frame byte positions, zero means hunting for the start byte
    localparam logic [PosW-1:0] POS_HUNT  = 4'd0;
    localparam logic [PosW-1:0] POS_HDR1  = 4'd1;
    localparam logic [PosW-1:0] POS_HDR2  = 4'd2;
    localparam logic [PosW-1:0] POS_HDR3  = 4'd3;
    localparam logic [PosW-1:0] POS_VAL_A = 4'd4;
    localparam logic [PosW-1:0] POS_VAL_B = 4'd5;
    localparam logic [PosW-1:0] POS_VAL_C = 4'd6;
    localparam logic [PosW-1:0] POS_VAL_D = 4'd7;
    localparam logic [PosW-1:0] POS_CHECK = 4'd8;

    localparam logic [AddrW-1:0] ADDR_UPLOAD_MODE = 3'd0;

    // upload_mode values: question-answer layout and active upload layout
    localparam logic LAYOUT_QUERY  = 1'b0;
    localparam logic LAYOUT_UPLOAD = 1'b1;

endpackage

>>> src/gas_sensor_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// gas_sensor_frame_parser_unit
// Hunts 9-byte sensor frames in a received byte stream, checks the header
// and checksum, and returns the decoded concentration and second value.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel: one received byte per transfer (rx_valid / rx_stall).
//   result channel: one transfer per frame that reaches its checksum byte,
//   carrying concentration, second_value and checksum_ok (res_valid /
//   res_stall). Frames with a bad checksum still produce a result.
//   APB port: register 0 (address 0) is upload_mode, 1 = active layout,
//   0 = passive question-answer layout; write it only while idle.
// Timing:
//   a byte is captured in an input register and parsed from there into the
//   output register, so the checksum byte's result passes through the input
//   register and then the output register before it is valid.
//   One byte is taken every cycle while rx_stall is low; the parse stage
//   updates the frame state once per byte, which sets the rate.
// Reset: parser hunts for a start byte, upload_mode is active, no result.
// Stall: a held result freezes the parse stage; the input register takes one
//   more byte if it is empty, then rx_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module gas_sensor_frame_parser_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    // received bytes
    input  logic                        rx_valid,
    output logic                        rx_stall,
    input  logic [gsfp_pkg::DataW-1:0]  rx_byte,
    // decoded frames
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [gsfp_pkg::ValueW-1:0] concentration,
    output logic [gsfp_pkg::ValueW-1:0] second_value,
    output logic                        checksum_ok,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gsfp_pkg::AddrW-1:0]  paddr,
    input  logic [gsfp_pkg::ApbW-1:0]   pwdata,
    output logic [gsfp_pkg::ApbW-1:0]   prdata,
    output logic                        pready
);
    import gsfp_pkg::*;

    logic                 mode_reg;
    logic                 in_valid_reg;
    logic [DataW-1:0]     in_byte_reg;
    logic [PosW-1:0]      pos_reg, pos_next;
    logic [DataW-1:0]     sum_reg, sum_next;
    logic [ValueW-1:0]    conc_reg, conc_next;
    logic [ValueW-1:0]    second_reg, second_next;
    logic                 out_valid_reg;
    logic [ValueW-1:0]    out_conc_reg;
    logic [ValueW-1:0]    out_second_reg;
    logic                 out_ok_reg;

    logic                 advance;
    logic                 do_parse;
    logic                 emit;
    logic                 hdr_ok;
    logic [DataW-1:0]     expect_sum;

    // configuration port
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_UPLOAD_MODE)
        begin
            prdata[0] = mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= LAYOUT_UPLOAD;
        end
        else if (psel && penable && pwrite && paddr == ADDR_UPLOAD_MODE)
        begin
            mode_reg <= pwdata[0];
        end
    end

    // pipeline flow: parse stage moves when the output slot is empty or being taken
    assign advance  = !out_valid_reg || !res_stall;
    assign do_parse = in_valid_reg && advance;
    assign rx_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!rx_stall)
        begin
            in_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // header check for the current position
    always_comb
    begin
        hdr_ok = 1'b1;
        if (mode_reg == LAYOUT_UPLOAD)
        begin
            case (pos_reg)
                POS_HDR1: hdr_ok = (in_byte_reg == ACTIVE_GAS);
                POS_HDR2: hdr_ok = (in_byte_reg == ACTIVE_UNIT);
                POS_HDR3: hdr_ok = (in_byte_reg == ACTIVE_DEC);
                default:  hdr_ok = 1'b1;
            endcase
        end
        else if (pos_reg == POS_HDR1)
        begin
            hdr_ok = (in_byte_reg == PASSIVE_CMD);
        end
    end

    assign expect_sum = DataW'(0) - sum_reg;
    assign emit       = do_parse && (pos_reg == POS_CHECK);

    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        conc_next   = conc_reg;
        second_next = second_reg;
        if (do_parse)
        begin
            if (pos_reg == POS_HUNT || pos_reg > POS_CHECK)
            begin
                if (in_byte_reg == START_BYTE)
                begin
                    sum_next = '0;
                    pos_next = POS_HDR1;
                end
                else
                begin
                    pos_next = POS_HUNT;
                end
            end
            else if (pos_reg == POS_CHECK)
            begin
                pos_next = POS_HUNT;
            end
            else if (!hdr_ok)
            begin
                pos_next = POS_HUNT;
            end
            else
            begin
                sum_next = sum_reg + in_byte_reg;
                pos_next = pos_reg + PosW'(1);
                // field capture, high byte first; the high byte clears the low one
                if (mode_reg == LAYOUT_UPLOAD)
                begin
                    case (pos_reg)
                        POS_VAL_A: conc_next                   = {in_byte_reg, {DataW{1'b0}}};
                        POS_VAL_B: conc_next[DataW-1:0]        = in_byte_reg;
                        POS_VAL_C: second_next                 = {in_byte_reg, {DataW{1'b0}}};
                        POS_VAL_D: second_next[DataW-1:0]      = in_byte_reg;
                        default: ;
                    endcase
                end
                else
                begin
                    case (pos_reg)
                        POS_HDR2:  conc_next                   = {in_byte_reg, {DataW{1'b0}}};
                        POS_HDR3:  conc_next[DataW-1:0]        = in_byte_reg;
                        POS_VAL_C: second_next                 = {in_byte_reg, {DataW{1'b0}}};
                        POS_VAL_D: second_next[DataW-1:0]      = in_byte_reg;
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_HUNT;
            sum_reg    <= '0;
            conc_reg   <= '0;
            second_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            conc_reg   <= conc_next;
            second_reg <= second_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_conc_reg   <= conc_reg;
            out_second_reg <= second_reg;
            out_ok_reg     <= (expect_sum == in_byte_reg);
        end
    end

    assign res_valid     = out_valid_reg;
    assign concentration = out_conc_reg;
    assign second_value  = out_second_reg;
    assign checksum_ok   = out_ok_reg;

endmodule
